// ----- rtl/msc_pkg.sv -----
package msc_pkg;

  localparam int NumCorners = 4;
  localparam int NumEdges   = 4;
  localparam int NumLanes   = 2 * NumEdges;
  localparam int WordW      = 32;
  localparam int DiffW      = WordW + 1;
  localparam int ProdW      = 2 * DiffW;
  localparam int DivSteps   = DiffW;
  localparam int CtrlLat    = DivSteps + 2;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [DiffW-1:0] sdiff_t;
  typedef logic        [DiffW-1:0] diff_t;
  typedef logic        [ProdW-1:0] prod_t;
  typedef logic        [1:0]       corner_t;
  typedef logic        [QPtrW-1:0] qptr_t;
  typedef logic        [QCntW-1:0] qcnt_t;

  localparam qcnt_t QFull = qcnt_t'(QDepth);

  // corner pair of each edge, in visiting order
  localparam corner_t EdgeEnd [NumEdges][2] = '{
    '{2'd0, 2'd1}, '{2'd1, 2'd2}, '{2'd2, 2'd3}, '{2'd3, 2'd0}
  };

  typedef struct packed {
    prod_t num;
    diff_t den;
    word_t pa;
    logic  neg;
  } lane_t;

  typedef struct packed {
    logic                vld;
    logic [NumEdges-1:0] mask;
  } ctrl_t;

  typedef struct packed {
    word_t sr;
    word_t sz;
    word_t er;
    word_t ez;
  } seg_t;

  function automatic diff_t mag(input sdiff_t x);
    return x[DiffW-1] ? diff_t'(~x) + diff_t'(1) : diff_t'(x);
  endfunction

endpackage

// ----- rtl/msc_front.sv -----
module msc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_acc_i,
  input  logic                level_we_i,
  input  msc_pkg::word_t      level_i,
  input  msc_pkg::word_t      value_i [msc_pkg::NumCorners],
  input  msc_pkg::word_t      rpos_i  [msc_pkg::NumCorners],
  input  msc_pkg::word_t      zpos_i  [msc_pkg::NumCorners],
  output msc_pkg::ctrl_t      ctrl_o,
  output msc_pkg::lane_t      lane_o  [msc_pkg::NumLanes]
);

  msc_pkg::word_t  level_q;

  logic                             s1_vld_q;
  logic [msc_pkg::NumCorners-1:0]   s1_above_q, s1_above_d;
  msc_pkg::sdiff_t                  s1_dl_q [msc_pkg::NumEdges];
  msc_pkg::sdiff_t                  s1_dl_d [msc_pkg::NumEdges];
  msc_pkg::sdiff_t                  s1_dv_q [msc_pkg::NumEdges];
  msc_pkg::sdiff_t                  s1_dv_d [msc_pkg::NumEdges];
  msc_pkg::sdiff_t                  s1_dp_q [msc_pkg::NumLanes];
  msc_pkg::sdiff_t                  s1_dp_d [msc_pkg::NumLanes];
  msc_pkg::word_t                   s1_pa_q [msc_pkg::NumLanes];
  msc_pkg::word_t                   s1_pa_d [msc_pkg::NumLanes];

  logic                             s2_vld_q;
  logic [msc_pkg::NumEdges-1:0]     s2_mask_q, s2_mask_d;
  msc_pkg::diff_t                   s2_mdl_q [msc_pkg::NumEdges];
  msc_pkg::diff_t                   s2_mdv_q [msc_pkg::NumEdges];
  msc_pkg::diff_t                   s2_mdp_q [msc_pkg::NumLanes];
  logic [msc_pkg::NumLanes-1:0]     s2_neg_q, s2_neg_d;
  msc_pkg::word_t                   s2_pa_q [msc_pkg::NumLanes];

  msc_pkg::ctrl_t                   ctrl_q;
  msc_pkg::lane_t                   lane_q [msc_pkg::NumLanes];
  msc_pkg::lane_t                   lane_d [msc_pkg::NumLanes];

  always_comb begin
    msc_pkg::corner_t a, b;
    for (int k = 0; k < msc_pkg::NumCorners; k++) begin
      s1_above_d[k] = value_i[k] >= level_q;
    end
    for (int e = 0; e < msc_pkg::NumEdges; e++) begin
      a = msc_pkg::EdgeEnd[e][0];
      b = msc_pkg::EdgeEnd[e][1];
      s1_dl_d[e] = {level_q[31], level_q} - {value_i[a][31], value_i[a]};
      s1_dv_d[e] = {value_i[b][31], value_i[b]} - {value_i[a][31], value_i[a]};
      s1_dp_d[e] = {rpos_i[b][31], rpos_i[b]} - {rpos_i[a][31], rpos_i[a]};
      s1_pa_d[e] = rpos_i[a];
      s1_dp_d[msc_pkg::NumEdges + e] = {zpos_i[b][31], zpos_i[b]} - {zpos_i[a][31], zpos_i[a]};
      s1_pa_d[msc_pkg::NumEdges + e] = zpos_i[a];
    end
  end

  always_comb begin
    for (int e = 0; e < msc_pkg::NumEdges; e++) begin
      s2_mask_d[e] = s1_above_q[msc_pkg::EdgeEnd[e][0]] ^ s1_above_q[msc_pkg::EdgeEnd[e][1]];
    end
    for (int l = 0; l < msc_pkg::NumLanes; l++) begin
      s2_neg_d[l] = s1_dl_q[l % msc_pkg::NumEdges][msc_pkg::DiffW-1]
                  ^ s1_dv_q[l % msc_pkg::NumEdges][msc_pkg::DiffW-1]
                  ^ s1_dp_q[l][msc_pkg::DiffW-1];
    end
  end

  always_comb begin
    for (int l = 0; l < msc_pkg::NumLanes; l++) begin
      lane_d[l].num = msc_pkg::prod_t'(s2_mdl_q[l % msc_pkg::NumEdges])
                    * msc_pkg::prod_t'(s2_mdp_q[l]);
      lane_d[l].den = s2_mdv_q[l % msc_pkg::NumEdges];
      lane_d[l].pa  = s2_pa_q[l];
      lane_d[l].neg = s2_neg_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      ctrl_q   <= '0;
    end else begin
      if (level_we_i) begin
        level_q <= level_i;
      end
      if (en_i) begin
        s1_vld_q    <= in_acc_i;
        s2_vld_q    <= s1_vld_q;
        ctrl_q.vld  <= s2_vld_q;
        ctrl_q.mask <= s2_mask_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_above_q <= s1_above_d;
      s2_mask_q  <= s2_mask_d;
      s2_neg_q   <= s2_neg_d;
      for (int e = 0; e < msc_pkg::NumEdges; e++) begin
        s1_dl_q[e]  <= s1_dl_d[e];
        s1_dv_q[e]  <= s1_dv_d[e];
        s2_mdl_q[e] <= msc_pkg::mag(s1_dl_q[e]);
        s2_mdv_q[e] <= msc_pkg::mag(s1_dv_q[e]);
      end
      for (int l = 0; l < msc_pkg::NumLanes; l++) begin
        s1_dp_q[l]  <= s1_dp_d[l];
        s1_pa_q[l]  <= s1_pa_d[l];
        s2_mdp_q[l] <= msc_pkg::mag(s1_dp_q[l]);
        s2_pa_q[l]  <= s1_pa_q[l];
        lane_q[l]   <= lane_d[l];
      end
    end
  end

  assign ctrl_o = ctrl_q;
  assign lane_o = lane_q;

endmodule

// ----- rtl/msc_div.sv -----
module msc_div (
  input  logic            clk_i,
  input  logic            en_i,
  input  msc_pkg::lane_t  lane_i,
  output msc_pkg::word_t  x_o
);

  msc_pkg::diff_t rem_q [msc_pkg::DivSteps+1];
  msc_pkg::diff_t low_q [msc_pkg::DivSteps+1];
  msc_pkg::diff_t quo_q [msc_pkg::DivSteps+1];
  msc_pkg::diff_t den_q [msc_pkg::DivSteps+1];
  msc_pkg::word_t pa_q  [msc_pkg::DivSteps+1];
  logic           neg_q [msc_pkg::DivSteps+1];
  msc_pkg::word_t x_q;

  logic [msc_pkg::DiffW:0] part  [msc_pkg::DivSteps];
  msc_pkg::diff_t          rem_d [msc_pkg::DivSteps];
  logic                    ge    [msc_pkg::DivSteps];

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int s = 0; s < msc_pkg::DivSteps; s++) begin
      part[s]  = {rem_q[s], low_q[s][msc_pkg::DiffW-1]};
      ge[s]    = part[s] >= {1'b0, den_q[s]};
      rem_d[s] = ge[s] ? msc_pkg::diff_t'(part[s] - {1'b0, den_q[s]})
                       : msc_pkg::diff_t'(part[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= lane_i.num[msc_pkg::ProdW-1:msc_pkg::DiffW];
      low_q[0] <= lane_i.num[msc_pkg::DiffW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= lane_i.den;
      pa_q[0]  <= lane_i.pa;
      neg_q[0] <= lane_i.neg;
      for (int s = 0; s < msc_pkg::DivSteps; s++) begin
        rem_q[s+1] <= rem_d[s];
        low_q[s+1] <= {low_q[s][msc_pkg::DiffW-2:0], 1'b0};
        quo_q[s+1] <= {quo_q[s][msc_pkg::DiffW-2:0], ge[s]};
        den_q[s+1] <= den_q[s];
        pa_q[s+1]  <= pa_q[s];
        neg_q[s+1] <= neg_q[s];
      end
      x_q <= neg_q[msc_pkg::DivSteps]
           ? pa_q[msc_pkg::DivSteps] - quo_q[msc_pkg::DivSteps][msc_pkg::WordW-1:0]
           : pa_q[msc_pkg::DivSteps] + quo_q[msc_pkg::DivSteps][msc_pkg::WordW-1:0];
    end
  end

  assign x_o = x_q;

endmodule

// ----- rtl/msc_back.sv -----
module msc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  msc_pkg::ctrl_t  ctrl_i,
  input  msc_pkg::word_t  x_i [msc_pkg::NumLanes],
  input  logic            pop_i,
  output logic            en_o,
  output logic            empty_o,
  output msc_pkg::seg_t   seg_o,
  output logic            last_o
);

  msc_pkg::ctrl_t ctrl_q [msc_pkg::CtrlLat];
  msc_pkg::ctrl_t cur;

  msc_pkg::seg_t  q_seg0 [msc_pkg::QDepth];
  msc_pkg::seg_t  q_seg1 [msc_pkg::QDepth];
  logic           q_two  [msc_pkg::QDepth];
  msc_pkg::qptr_t wr_q, rd_q;
  msc_pkg::qcnt_t cnt_q, cnt_d;
  logic           half_q;

  logic           en, push, pop_acc, done, saddle;
  msc_pkg::corner_t lo, hi, e0, e1;
  msc_pkg::seg_t  seg0, seg1;

  assign cur = ctrl_q[msc_pkg::CtrlLat-1];
  assign en  = cnt_q != msc_pkg::QFull;

  always_comb begin
    lo = '0;
    hi = '0;
    for (int e = msc_pkg::NumEdges - 1; e >= 0; e--) begin
      if (cur.mask[e]) begin
        lo = msc_pkg::corner_t'(e);
      end
    end
    for (int e = 0; e < msc_pkg::NumEdges; e++) begin
      if (cur.mask[e]) begin
        hi = msc_pkg::corner_t'(e);
      end
    end
    saddle = &cur.mask;
    // saddle pairs edges 0-1 and 2-3
    e0 = saddle ? 2'd0 : lo;
    e1 = saddle ? 2'd1 : hi;
    seg0.sr = x_i[3'(e0)];
    seg0.sz = x_i[3'(msc_pkg::NumEdges) + 3'(e0)];
    seg0.er = x_i[3'(e1)];
    seg0.ez = x_i[3'(msc_pkg::NumEdges) + 3'(e1)];
    seg1.sr = x_i[2];
    seg1.sz = x_i[3'(msc_pkg::NumEdges + 2)];
    seg1.er = x_i[3];
    seg1.ez = x_i[3'(msc_pkg::NumEdges + 3)];
  end

  assign push    = en && cur.vld && (|cur.mask);
  assign pop_acc = pop_i && (cnt_q != '0);
  assign done    = pop_acc && (!q_two[rd_q] || half_q);
  assign cnt_d   = cnt_q + msc_pkg::qcnt_t'(push) - msc_pkg::qcnt_t'(done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msc_pkg::CtrlLat; i++) begin
        ctrl_q[i] <= '0;
      end
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      half_q <= 1'b0;
    end else begin
      if (en) begin
        ctrl_q[0] <= ctrl_i;
        for (int i = 1; i < msc_pkg::CtrlLat; i++) begin
          ctrl_q[i] <= ctrl_q[i-1];
        end
      end
      if (push) begin
        wr_q <= wr_q + msc_pkg::qptr_t'(1);
      end
      if (done) begin
        rd_q   <= rd_q + msc_pkg::qptr_t'(1);
        half_q <= 1'b0;
      end else if (pop_acc) begin
        half_q <= 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_seg0[wr_q] <= seg0;
      q_seg1[wr_q] <= seg1;
      q_two[wr_q]  <= saddle;
    end
  end

  assign en_o    = en;
  assign empty_o = cnt_q == '0;
  assign seg_o   = half_q ? q_seg1[rd_q] : q_seg0[rd_q];
  assign last_o  = !q_two[rd_q] || half_q;

endmodule

// ----- rtl/marching_squares_cell_top.sv -----
// An accepted cell crosses the front, divider and result queue to the result ports.
// Throughput: one cell per cycle unless stalled; a saddle cell yields two words.
// Most of the latency is the 33-stage restoring divider, one quotient bit per stage.
// Input stalls only while the 4-entry result queue is full.
// Reset (rst_ni low, asynchronous): pipeline and result queue empty, iso_level = 0.
module marching_squares_cell_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 iso_level_we_i,
  input  logic signed [31:0]   iso_level_i,
  input  logic                 push,
  output logic                 full,
  input  logic signed [31:0]   value_c0_i,
  input  logic signed [31:0]   value_c1_i,
  input  logic signed [31:0]   value_c2_i,
  input  logic signed [31:0]   value_c3_i,
  input  logic signed [31:0]   rpos_c0_i,
  input  logic signed [31:0]   rpos_c1_i,
  input  logic signed [31:0]   rpos_c2_i,
  input  logic signed [31:0]   rpos_c3_i,
  input  logic signed [31:0]   zpos_c0_i,
  input  logic signed [31:0]   zpos_c1_i,
  input  logic signed [31:0]   zpos_c2_i,
  input  logic signed [31:0]   zpos_c3_i,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   start_r_o,
  output logic signed [31:0]   start_z_o,
  output logic signed [31:0]   end_r_o,
  output logic signed [31:0]   end_z_o,
  output logic                 last_of_cell_o
);

  msc_pkg::word_t value [msc_pkg::NumCorners];
  msc_pkg::word_t rpos  [msc_pkg::NumCorners];
  msc_pkg::word_t zpos  [msc_pkg::NumCorners];
  msc_pkg::ctrl_t ctrl;
  msc_pkg::lane_t lane  [msc_pkg::NumLanes];
  msc_pkg::word_t x     [msc_pkg::NumLanes];
  msc_pkg::seg_t  seg;
  logic           en;

  assign value = '{value_c0_i, value_c1_i, value_c2_i, value_c3_i};
  assign rpos  = '{rpos_c0_i, rpos_c1_i, rpos_c2_i, rpos_c3_i};
  assign zpos  = '{zpos_c0_i, zpos_c1_i, zpos_c2_i, zpos_c3_i};

  assign full = !en;

  msc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_acc_i   (push && en),
    .level_we_i (iso_level_we_i),
    .level_i    (iso_level_i),
    .value_i    (value),
    .rpos_i     (rpos),
    .zpos_i     (zpos),
    .ctrl_o     (ctrl),
    .lane_o     (lane)
  );

  for (genvar l = 0; l < msc_pkg::NumLanes; l++) begin : g_lane
    msc_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (lane[l]),
      .x_o    (x[l])
    );
  end

  msc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .x_i     (x),
    .pop_i   (pop),
    .en_o    (en),
    .empty_o (empty),
    .seg_o   (seg),
    .last_o  (last_of_cell_o)
  );

  assign start_r_o = seg.sr;
  assign start_z_o = seg.sz;
  assign end_r_o   = seg.er;
  assign end_z_o   = seg.ez;

endmodule

// ----- rtl/msc_chk.sv -----
module msc_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic signed [31:0]  start_r_o,
  input logic signed [31:0]  start_z_o,
  input logic signed [31:0]  end_r_o,
  input logic signed [31:0]  end_z_o,
  input logic                last_of_cell_o
);

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result side not empty in reset");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(start_r_o) && $stable(start_z_o)
      && $stable(end_r_o) && $stable(end_z_o) && $stable(last_of_cell_o))
    else $error("waiting word changed");

  a_saddle_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !last_of_cell_o |=> !empty && last_of_cell_o)
    else $error("second segment of cell missing");

  a_full_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("full with nothing to pop");

  a_known_hs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({push, pop, full, empty}))
    else $error("handshake signal unknown");

endmodule

bind marching_squares_cell_top msc_chk u_msc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .start_r_o      (start_r_o),
  .start_z_o      (start_z_o),
  .end_r_o        (end_r_o),
  .end_z_o        (end_z_o),
  .last_of_cell_o (last_of_cell_o)
);

// ----- sim/testbench.sv -----
module testbench;
  typedef msc_pkg::word_t word_t;

  localparam int LatencyCycles = 38;
  localparam int RandCells     = 1650;
  localparam int CycleLimit    = 400000;

  typedef struct {
    word_t v[4];
    word_t r[4];
    word_t z[4];
  } cell_t;

  typedef struct {
    word_t sr;
    word_t sz;
    word_t er;
    word_t ez;
    logic  last;
  } segment_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic iso_level_we_i = 1'b0;
  word_t iso_level_i = '0;
  logic push = 1'b0;
  logic full;
  word_t value_c_i [4];
  word_t rpos_c_i [4];
  word_t zpos_c_i [4];
  logic empty;
  logic pop = 1'b0;
  word_t start_r_o, start_z_o, end_r_o, end_z_o;
  logic last_of_cell_o;

  word_t level_q = '0;
  segment_t seg_queue [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit hold_rx = 1'b0;

  initial begin
    for (int k = 0; k < 4; k++) begin
      value_c_i[k] = '0;
      rpos_c_i[k] = '0;
      zpos_c_i[k] = '0;
    end
  end

  always #2 clk_i = ~clk_i;

  marching_squares_cell_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .iso_level_we_i(iso_level_we_i), .iso_level_i(iso_level_i),
    .push(push), .full(full),
    .value_c0_i(value_c_i[0]), .value_c1_i(value_c_i[1]),
    .value_c2_i(value_c_i[2]), .value_c3_i(value_c_i[3]),
    .rpos_c0_i(rpos_c_i[0]), .rpos_c1_i(rpos_c_i[1]),
    .rpos_c2_i(rpos_c_i[2]), .rpos_c3_i(rpos_c_i[3]),
    .zpos_c0_i(zpos_c_i[0]), .zpos_c1_i(zpos_c_i[1]),
    .zpos_c2_i(zpos_c_i[2]), .zpos_c3_i(zpos_c_i[3]),
    .empty(empty), .pop(pop),
    .start_r_o(start_r_o), .start_z_o(start_z_o),
    .end_r_o(end_r_o), .end_z_o(end_z_o),
    .last_of_cell_o(last_of_cell_o)
  );

  function automatic word_t cross_point(longint pa, longint pb, longint va, longint vb,
                                        longint lvl);
    longint dl, dv, dp;
    logic [127:0] q;
    logic [63:0] mdl, mdv, mdp;
    bit neg;
    dl = lvl - va;
    dv = vb - va;
    dp = pb - pa;
    if (dv == 0 || dl == 0 || dp == 0) return word_t'(pa);
    mdl = dl < 0 ? -dl : dl;
    mdv = dv < 0 ? -dv : dv;
    mdp = dp < 0 ? -dp : dp;
    q = (128'(mdl) * 128'(mdp)) / 128'(mdv);
    neg = ((dl < 0) != (dv < 0)) != (dp < 0);
    return neg ? word_t'(pa - longint'(q[63:0])) : word_t'(pa + longint'(q[63:0]));
  endfunction

  task automatic predict_segments(input cell_t c);
    word_t cr [4], cz [4];
    int n, a, b;
    bit above [4];
    segment_t s;
    n = 0;
    for (int k = 0; k < 4; k++) above[k] = c.v[k] >= level_q;
    for (int k = 0; k < 4; k++) begin
      a = k;
      b = (k + 1) % 4;
      if (above[a] != above[b]) begin
        cr[n] = cross_point(c.r[a], c.r[b], c.v[a], c.v[b], level_q);
        cz[n] = cross_point(c.z[a], c.z[b], c.v[a], c.v[b], level_q);
        n++;
      end
    end
    if (n < 2) return;
    s = '{cr[0], cz[0], cr[1], cz[1], n != 4};
    seg_queue = {seg_queue, s};
    if (n == 4) begin
      s = '{cr[2], cz[2], cr[3], cz[3], 1'b1};
      seg_queue = {seg_queue, s};
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // push stays high after an accept; it drops only before an idle stretch
  task automatic send_cell(input cell_t c, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      value_c_i[k] <= c.v[k];
      rpos_c_i[k] <= c.r[k];
      zpos_c_i[k] <= c.z[k];
    end
    do @(posedge clk_i); while (full);
    predict_segments(c);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (seg_queue.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 4) @(posedge clk_i);
  endtask

  task automatic write_level(input word_t lvl);
    drain();
    iso_level_we_i <= 1'b1;
    iso_level_i <= lvl;
    @(posedge clk_i);
    iso_level_we_i <= 1'b0;
    level_q = lvl;
  endtask

  function automatic word_t rand_word(input int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'(32'sh8000_0000);
      2: return word_t'(32'sh7fff_ffff);
      default: return word_t'($signed($urandom_range(0, 8000)) - 4000) <<< 8;
    endcase
  endfunction

  function automatic cell_t rand_cell(input bit wide);
    cell_t c;
    int m;
    for (int k = 0; k < 4; k++) begin
      m = wide ? ($urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0) : 3;
      c.v[k] = ($urandom_range(0, 15) == 0) ? level_q : rand_word(m);
      c.r[k] = rand_word(wide ? $urandom_range(0, 3) : 3);
      c.z[k] = rand_word(wide ? $urandom_range(0, 3) : 3);
    end
    return c;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random pop, checked at the accepting edge
  initial begin
    int gap;
    segment_t e;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (gap > 0 || hold_rx) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (hold_rx) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (seg_queue.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = seg_queue.pop_front();
        if (start_r_o !== e.sr) report_mismatch("start_r", start_r_o, e.sr);
        if (start_z_o !== e.sz) report_mismatch("start_z", start_z_o, e.sz);
        if (end_r_o !== e.er) report_mismatch("end_r", end_r_o, e.er);
        if (end_z_o !== e.ez) report_mismatch("end_z", end_z_o, e.ez);
        if (last_of_cell_o !== e.last) report_mismatch("last", last_of_cell_o, e.last);
      end
    end
  end

  initial begin
    cell_t dir [8];
    cell_t c;
    word_t levels [5];
    bit dense;
    rst_ni <= 1'b0;
    levels = '{32'sh0001_0000, 32'sh8000_0000, 32'sh7fff_ffff, -32'sh0002_8000, 32'sh0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // uniform below, uniform above, corner on level, saddle, extremes
    dir[0] = '{'{-5, -6, -7, -8}, '{0, 1, 2, 3}, '{0, 1, 2, 3}};
    dir[1] = '{'{5, 6, 7, 8}, '{0, 1, 2, 3}, '{0, 1, 2, 3}};
    dir[2] = '{'{0, -65536, -65536, -65536}, '{0, 65536, 65536, 0}, '{0, 0, 65536, 65536}};
    dir[3] = '{'{65536, -65536, 65536, -65536}, '{0, 65536, 65536, 0},
               '{0, 0, 65536, 65536}};
    dir[4] = '{'{32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
               '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000},
               '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000}};
    dir[5] = '{'{-1, -1, 32'sh7fff_ffff, 32'sh7fff_ffff}, '{-1, 0, 32'sh7fff_ffff, 5},
               '{32'sh8000_0000, -1, 0, 32'sh7fff_ffff}};
    dir[6] = '{'{-65536, 65536, -65536, 65536}, '{100, 200, 300, 400},
               '{-400, -300, -200, -100}};
    dir[7] = '{'{1, 0, -1, 0}, '{7, 7, 7, 7}, '{-9, 9, -9, 9}};
    foreach (dir[i]) send_cell(dir[i], $urandom_range(0, 3));
    write_level(32'sh8000_0000);
    foreach (dir[i]) send_cell(dir[i], 0);
    write_level(32'sh7fff_ffff);
    foreach (dir[i]) send_cell(dir[i], 0);
    for (int ph = 0; ph < 5; ph++) begin
      write_level(levels[ph]);
      if (ph == 2) begin
        hold_rx = 1'b1;
        fork
          begin repeat (300) @(posedge clk_i); hold_rx = 1'b0; end
        join_none
      end
      for (int i = 0; i < RandCells / 5; i++) begin
        dense = $urandom_range(0, 2) == 0;
        c = rand_cell(ph != 3);
        send_cell(c, dense ? 0 : $urandom_range(0, 15));
        if (i == 100) drain();
      end
    end
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/msc_pkg.sv
rtl/msc_front.sv
rtl/msc_div.sv
rtl/msc_back.sv
rtl/marching_squares_cell_top.sv
rtl/msc_chk.sv
sim/testbench.sv
